// ----- rtl/bmsl_pkg.sv -----
// Shared types and constants for the motor speed loop: register indexes,
// configuration bundle, result word and field widths. No dependencies.
`default_nettype none

package bmsl_pkg;

  // Field widths fixed by the register map and the sample format.
  localparam int SPEED_W  = 16;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int GAIN_W   = 16;
  localparam int THR_W    = 10;
  localparam int DUTY_W   = 14;
  localparam int SDUTY_W  = DUTY_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0] GAIN_RST      = '0;
  localparam logic [THR_W-1:0]  BANG_THR_RST  = THR_W'(20);
  localparam logic [DUTY_W-1:0] BANG_DUTY_RST = DUTY_W'(950);
  localparam logic [DUTY_W-1:0] FAST_LIM_RST  = DUTY_W'(950);
  localparam logic [DUTY_W-1:0] SLOW_LIM_RST  = DUTY_W'(400);
  localparam logic [THR_W-1:0]  SPLIT_RST     = THR_W'(20);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_BANG_THR    = 3'd3,
    REG_BANG_DUTY   = 3'd4,
    REG_FAST_LIMIT  = 3'd5,
    REG_SLOW_LIMIT  = 3'd6,
    REG_SPEED_SPLIT = 3'd7
  } reg_idx_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0] gain_prop;
    logic [GAIN_W-1:0] gain_integ;
    logic [GAIN_W-1:0] gain_deriv;
    logic [THR_W-1:0]  bang_threshold;
    logic [DUTY_W-1:0] bang_duty;
    logic [DUTY_W-1:0] fast_limit;
    logic [DUTY_W-1:0] slow_limit;
    logic [THR_W-1:0]  speed_split;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic signed [SDUTY_W-1:0] signed_duty;
    logic [DUTY_W-1:0]         duty_forward;
    logic [DUTY_W-1:0]         duty_reverse;
    logic                      bang_mode;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/bmsl_cfg.sv -----
// Configuration register file of the motor speed loop.
// Depends on bmsl_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module bmsl_cfg
  import bmsl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  // Register writes, each field truncated to its own width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop      <= GAIN_RST;
      cfg_r.gain_integ     <= GAIN_RST;
      cfg_r.gain_deriv     <= GAIN_RST;
      cfg_r.bang_threshold <= BANG_THR_RST;
      cfg_r.bang_duty      <= BANG_DUTY_RST;
      cfg_r.fast_limit     <= FAST_LIM_RST;
      cfg_r.slow_limit     <= SLOW_LIM_RST;
      cfg_r.speed_split    <= SPLIT_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN_PROP:   cfg_r.gain_prop      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_INTEG:  cfg_r.gain_integ     <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_DERIV:  cfg_r.gain_deriv     <= cfg_wdata[GAIN_W-1:0];
        REG_BANG_THR:    cfg_r.bang_threshold <= cfg_wdata[THR_W-1:0];
        REG_BANG_DUTY:   cfg_r.bang_duty      <= cfg_wdata[DUTY_W-1:0];
        REG_FAST_LIMIT:  cfg_r.fast_limit     <= cfg_wdata[DUTY_W-1:0];
        REG_SLOW_LIMIT:  cfg_r.slow_limit     <= cfg_wdata[DUTY_W-1:0];
        REG_SPEED_SPLIT: cfg_r.speed_split    <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/bmsl_pid.sv -----
// Control law of the motor speed loop: bang-bang decision, incremental PID,
// speed-dependent clamp and PWM split, plus the PID state registers.
// Depends on bmsl_pkg for cfg_t, result_t and widths.
`default_nettype none

module bmsl_pid
  import bmsl_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step_en,
  input  wire logic signed [SPEED_W-1:0] meas,
  input  wire logic signed [SPEED_W-1:0] targ,
  input  cfg_t                           cfg,
  output result_t                        res
);

  localparam int DP_W   = ERR_W + 1;   // err - last_err
  localparam int DD_W   = ERR_W + 2;   // err - 2*last_err + prev_err
  localparam int PP_W   = GAIN_W + 1 + DP_W;
  localparam int PI_W   = GAIN_W + 1 + ERR_W;
  localparam int PD_W   = GAIN_W + 1 + DD_W;
  localparam int SUM_W  = PD_W + 2;
  localparam int INC_W  = SUM_W - 8;
  localparam int RAW_W  = INC_W + 1;

  // PID state.
  logic signed [SDUTY_W-1:0] accum_r;
  logic signed [ERR_W-1:0]   last_err_r;
  logic signed [ERR_W-1:0]   prev_err_r;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  thr_s;
  logic                     bang_pos;
  logic                     bang_neg;
  logic                     bang;
  logic signed [DP_W-1:0]   d_prop;
  logic signed [DD_W-1:0]   d_deriv;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PI_W-1:0]   prod_i;
  logic signed [PD_W-1:0]   prod_d;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_rnd;
  logic signed [INC_W-1:0]  inc;
  logic signed [RAW_W-1:0]  pid_duty;
  logic signed [RAW_W-1:0]  bang_mag;
  logic signed [RAW_W-1:0]  raw_duty;
  logic [DUTY_W-1:0]        lim;
  logic signed [RAW_W-1:0]  lim_s;
  logic signed [SDUTY_W-1:0] duty;
  logic signed [SDUTY_W-1:0] duty_neg;

  // Error and bang-bang decision.
  assign err      = $signed({targ[SPEED_W-1], targ}) - $signed({meas[SPEED_W-1], meas});
  assign thr_s    = $signed({{(ERR_W-THR_W){1'b0}}, cfg.bang_threshold});
  assign bang_pos = err > thr_s;
  assign bang_neg = err < -thr_s;
  assign bang     = bang_pos || bang_neg;

  // Incremental PID term, exact sum then truncation toward zero.
  assign d_prop  = DP_W'(err) - DP_W'(last_err_r);
  assign d_deriv = DD_W'(err) - (DD_W'(last_err_r) <<< 1) + DD_W'(prev_err_r);
  assign prod_p  = $signed({1'b0, cfg.gain_prop})  * d_prop;
  assign prod_i  = $signed({1'b0, cfg.gain_integ}) * err;
  assign prod_d  = $signed({1'b0, cfg.gain_deriv}) * d_deriv;
  assign sum     = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
  assign sum_rnd = sum + (sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
  assign inc     = sum_rnd[SUM_W-1:8];
  assign pid_duty = RAW_W'(accum_r) + RAW_W'(inc);

  // Duty before the clamp.
  assign bang_mag = $signed({{(RAW_W-DUTY_W){1'b0}}, cfg.bang_duty});
  always_comb begin
    if (bang_pos) begin
      raw_duty = bang_mag;
    end else if (bang_neg) begin
      raw_duty = -bang_mag;
    end else begin
      raw_duty = pid_duty;
    end
  end

  // Speed-dependent clamp; speed equal to the split takes the fast limit.
  assign lim = ($signed({meas[SPEED_W-1], meas}) >=
                $signed({{(ERR_W-THR_W){1'b0}}, cfg.speed_split})) ?
               cfg.fast_limit : cfg.slow_limit;
  assign lim_s = $signed({{(RAW_W-DUTY_W){1'b0}}, lim});

  always_comb begin
    if (raw_duty >= lim_s) begin
      duty = SDUTY_W'(lim_s);
    end else if (raw_duty <= -lim_s) begin
      duty = SDUTY_W'(-lim_s);
    end else begin
      duty = SDUTY_W'(raw_duty);
    end
  end

  // Split into the two one-sided PWM duties.
  assign duty_neg         = -duty;
  assign res.signed_duty  = duty;
  assign res.duty_forward = duty[SDUTY_W-1] ? duty_neg[DUTY_W-1:0] : '0;
  assign res.duty_reverse = duty[SDUTY_W-1] ? '0 : duty[DUTY_W-1:0];
  assign res.bang_mode    = bang;

  // State update on PID steps only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r    <= '0;
      last_err_r <= '0;
      prev_err_r <= '0;
    end else if (step_en && !bang) begin
      accum_r    <= duty;
      prev_err_r <= last_err_r;
      last_err_r <= err;
    end
  end

  // A bang step leaves all PID state alone.
  a_bang_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && bang |=> $stable(accum_r) && $stable(last_err_r) && $stable(prev_err_r))
    else $error("PID state changed on a bang step");

  // A PID step shifts the error history.
  a_pid_shifts_err: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !bang |=> prev_err_r == $past(last_err_r))
    else $error("error history not shifted on a PID step");

  // The driven duty stays within the limit chosen by the speed.
  a_duty_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> (RAW_W'(duty) <= lim_s) && (RAW_W'(duty) >= -lim_s))
    else $error("duty outside the selected limit");

endmodule

`default_nettype wire

// ----- rtl/bang_pid_motor_speed_loop.sv -----
// Top level of the motor speed loop: sample register, control law and
// result register with valid/stall handshakes. Depends on bmsl_pkg,
// bmsl_cfg and bmsl_pid.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per sample: the
//   measured and the target speed, both signed. Result channel (out_valid /
//   out_stall) returns exactly one word per sample: the clamped signed duty,
//   the forward and reverse PWM duties and the bang-bang flag.
//   A word is taken at a clock edge with valid high and stall low.
//   A sample taken at an edge is held in the sample register, passes the
//   control law and is loaded into the result register once that register
//   is free or its word is taken, which raises out_valid.
//   Throughput: one sample per cycle while out_stall is low. On a PID
//   step the duty accumulator and error history update in the same edge
//   that loads the result, so the next sample sees them at once.
//   When out_stall is high with a result waiting, the result holds and the
//   sample register still takes one word; in_stall rises only when both are
//   full.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at
//   the next edge; the user must make them while the block is idle, which
//   is not enforced. Reset (rst_n low, synchronous) empties both registers,
//   restores register defaults and clears accumulator and error history.
`default_nettype none

module bang_pid_motor_speed_loop
  import bmsl_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input channel
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic signed [SPEED_W-1:0]   in_measured_speed,
  input  wire logic signed [SPEED_W-1:0]   in_target_speed,
  // Result channel
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic signed [SDUTY_W-1:0]   out_signed_duty,
  output      logic [DUTY_W-1:0]           out_duty_forward,
  output      logic [DUTY_W-1:0]           out_duty_reverse,
  output      logic                        out_bang_mode,
  // Configuration port
  input  wire logic                        cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_wdata
);

  cfg_t    cfg;
  result_t res;
  result_t res_r;

  logic                      smp_valid_r;
  logic signed [SPEED_W-1:0] meas_r;
  logic signed [SPEED_W-1:0] targ_r;
  logic                      out_valid_r;
  logic                      advance;
  logic                      in_take;

  // Flow control: the sample moves on unless the result register is stalled.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = smp_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  bmsl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bmsl_pid u_pid (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (smp_valid_r && advance),
    .meas    (meas_r),
    .targ    (targ_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Sample register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_take) begin
      smp_valid_r <= 1'b1;
    end else if (advance) begin
      smp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      meas_r <= in_measured_speed;
      targ_r <= in_target_speed;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= smp_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && smp_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_signed_duty  = res_r.signed_duty;
  assign out_duty_forward = res_r.duty_forward;
  assign out_duty_reverse = res_r.duty_reverse;
  assign out_bang_mode    = res_r.bang_mode;

  // Only one PWM channel is driven at a time.
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty_forward == '0) || (out_duty_reverse == '0))
    else $error("both PWM channels driven");

  // The forward duty is the magnitude of a negative signed duty.
  a_forward_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_signed_duty[SDUTY_W-1] |->
      out_duty_forward == DUTY_W'(-out_signed_duty))
    else $error("forward duty does not match signed duty");

  // A waiting result is never dropped while the receiver stalls.
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("result lost under stall");

endmodule

`default_nettype wire
